/* rtl/esbk_pkg.sv */
// Shared types and constants for the exchange sort by key block.
`timescale 1ns / 1ps

package esbk_pkg;

  localparam int unsigned KeyW  = 32;
  localparam int unsigned TagW  = 16;
  localparam int unsigned RankW = 7;

  typedef struct packed {
    logic signed [KeyW-1:0] amount_key;
    logic        [TagW-1:0] item_tag;
    logic                   final_item;
  } in_t;

  typedef struct packed {
    logic        [RankW-1:0] rank;
    logic signed [KeyW-1:0]  sorted_key;
    logic        [TagW-1:0]  sorted_tag;
    logic                    end_of_run;
    logic                    overflow;
  } out_t;

  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic        [TagW-1:0] tag;
  } record_t;

endpackage

/* rtl/esbk_store.sv */
// Record store with one write port and one registered read port.
`timescale 1ns / 1ps

module esbk_store #(
  parameter int unsigned Depth = 64
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [$clog2(Depth)-1:0]      wr_addr_i,
  input  esbk_pkg::record_t             wr_data_i,
  input  logic [$clog2(Depth)-1:0]      rd_addr_i,
  output esbk_pkg::record_t             rd_data_o
);
  import esbk_pkg::*;

  record_t mem_q [Depth];
  record_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/exchange_sort_by_key.sv */
// Top level of the exchange sort by key block: loader, sort sequencer and output.
//
//   Channel   Handshake                 Payload
//   input     start / busy              item_i   (esbk_pkg::in_t)
//   result    result_valid_o (strobe)   result_o (esbk_pkg::out_t)
//
// Loading takes one transaction per cycle while busy is low. After the final item
// of a set, N records being held, the sort runs one compare pass per row through the
// states S_ROW, S_FIRST, S_SCAN and S_WB, then after the S_EPRE read set-up state
// and the output register N results leave on consecutive cycles. Reset clears the
// sequencer, the count and the dropped flag; store contents stay undefined. The
// receiver cannot stall.
`timescale 1ns / 1ps

module exchange_sort_by_key #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  esbk_pkg::in_t  item_i,
  output logic           result_valid_o,
  output esbk_pkg::out_t result_o
);
  import esbk_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_ITEMS);
  localparam int unsigned CntW  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned WideW = (CntW > RankW) ? CntW : RankW;

  typedef enum logic [2:0] {
    S_IDLE, S_ROW, S_FIRST, S_SCAN, S_WB, S_EPRE, S_EMIT
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   count_q;
  logic              dropped_q;
  logic [AddrW-1:0]  i_q, j_q, k_q;
  record_t           held_q;
  logic              valid_q;
  out_t              res_q;

  logic              accept;
  logic              full;
  logic [CntW-1:0]   count_d;
  logic [CntW-1:0]   last_idx;
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  record_t           wr_data;
  logic [AddrW-1:0]  rd_addr;
  record_t           rd_data;
  logic              less;
  logic [WideW-1:0]  rank_wide;

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign full     = (count_q == CntW'(MAX_ITEMS));
  assign count_d  = full ? count_q : count_q + CntW'(1);
  assign last_idx = count_q - CntW'(1);
  assign less     = ($signed(rd_data.key) < $signed(held_q.key));
  assign rank_wide = WideW'(k_q) + WideW'(1);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = i_q;
    wr_data = held_q;
    rd_addr = '0;
    unique case (state_q)
      S_IDLE: begin
        wr_en          = accept && !full;
        wr_addr        = count_q[AddrW-1:0];
        wr_data.key    = item_i.amount_key;
        wr_data.tag    = item_i.item_tag;
      end
      S_ROW:   rd_addr = i_q;
      S_FIRST: rd_addr = i_q + AddrW'(1);
      S_SCAN: begin
        wr_en   = less;
        wr_addr = j_q;
        rd_addr = j_q + AddrW'(1);
      end
      S_WB:    wr_en   = 1'b1;
      S_EPRE:  rd_addr = '0;
      S_EMIT:  rd_addr = k_q + AddrW'(1);
      default: ;
    endcase
  end

  esbk_store #(
    .Depth(MAX_ITEMS)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      dropped_q <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      held_q    <= '0;
      valid_q   <= 1'b0;
      res_q     <= '0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            count_q <= count_d;
            if (full) begin
              dropped_q <= 1'b1;
            end
            if (item_i.final_item) begin
              i_q <= '0;
              state_q <= (count_d > CntW'(1)) ? S_ROW : S_EPRE;
            end
          end
        end
        S_ROW: state_q <= S_FIRST;
        S_FIRST: begin
          held_q  <= rd_data;
          j_q     <= i_q + AddrW'(1);
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (less) begin
            held_q <= rd_data;
          end
          j_q <= j_q + AddrW'(1);
          if (CntW'(j_q) == last_idx) begin
            state_q <= S_WB;
          end
        end
        S_WB: begin
          i_q <= i_q + AddrW'(1);
          state_q <= (CntW'(i_q) + CntW'(1) == last_idx) ? S_EPRE : S_ROW;
        end
        S_EPRE: begin
          k_q     <= '0;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          valid_q          <= 1'b1;
          res_q.rank       <= rank_wide[RankW-1:0];
          res_q.sorted_key <= rd_data.key;
          res_q.sorted_tag <= rd_data.tag;
          res_q.end_of_run <= (CntW'(k_q) == last_idx);
          res_q.overflow   <= dropped_q;
          k_q              <= k_q + AddrW'(1);
          if (CntW'(k_q) == last_idx) begin
            count_q   <= '0;
            dropped_q <= 1'b0;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule
